// ===== rtl/core/bb2d_pkg.sv =====
// Shared types and constants for the 2x2 box blur with decay.
`timescale 1ns / 1ps
package bb2d_pkg;

  localparam int unsigned MAX_WIDTH  = 62;
  localparam int unsigned MAX_HEIGHT = 64;
  localparam int unsigned NCELL      = MAX_WIDTH + 1;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned ROW_W  = 6;
  localparam int unsigned WID_W  = 6;
  localparam int unsigned HGT_W  = 7;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned DATA_W = 8;

  localparam logic [WID_W-1:0] WIDTH_MIN  = WID_W'(2);
  localparam logic [WID_W-1:0] WIDTH_MAX  = WID_W'(MAX_WIDTH);
  localparam logic [HGT_W-1:0] HEIGHT_MIN = HGT_W'(2);
  localparam logic [HGT_W-1:0] HEIGHT_MAX = HGT_W'(MAX_HEIGHT);

  localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(45);
  localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(35);
  localparam logic [PIX_W-1:0] DECAY_RST  = PIX_W'(8);
  localparam logic             BORDER_RST = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_DECAY_AMOUNT = 2'd2,
    REG_CLEAR_BORDER = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_of_frame;
  } res_t;

  // Drive for the row of window cells.
  typedef struct packed {
    logic             shift;
    logic [PIX_W-1:0] ins_pix;
    logic [WID_W-1:0] width;
  } chain_ctl_t;

endpackage

// ===== rtl/core/bb2d_if.sv =====
// Valid/ready channel interfaces: pixel input, result output, register writes.
`timescale 1ns / 1ps
interface bb2d_pix_if import bb2d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bb2d_res_if import bb2d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_of_frame;

  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

interface bb2d_cfg_if import bb2d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bb2d_cell.sv =====
// One pixel cell of the window chain.
`timescale 1ns / 1ps
module bb2d_cell import bb2d_pkg::*; (
  input  logic             clk_i,
  input  chain_ctl_t       ctl_i,
  input  logic [WID_W-1:0] idx_i,
  input  logic [PIX_W-1:0] next_i,
  output logic [PIX_W-1:0] pix_o
);

  logic [PIX_W-1:0] pix_q, pix_d;

  // The cell at the row width takes the new pixel; lower cells take their neighbor.
  assign pix_d = (idx_i == ctl_i.width) ? ctl_i.ins_pix : next_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

// ===== rtl/core/bb2d_out_buf.sv =====
// Two-entry result buffer between the core and the output channel.
`timescale 1ns / 1ps
module bb2d_out_buf import bb2d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  res_t              push_data_i,
  bb2d_res_if.source        out_o
);

  res_t       ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o      = (cnt_q != 2'd2);
  assign out_o.valid         = (cnt_q != 2'd0);
  assign out_o.pixel_out     = ent_q[rd_q].pixel_out;
  assign out_o.last_of_frame = ent_q[rd_q].last_of_frame;

  assign push = push_valid_i && push_ready_o;
  assign pop  = out_o.valid && out_o.ready;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/bb2d_ctrl.sv =====
// Frame counters, registers, blur arithmetic and end-of-frame flush sequencer.
`timescale 1ns / 1ps
module bb2d_ctrl import bb2d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  bb2d_pix_if.sink         in_i,
  bb2d_cfg_if.sink         cfg_i,
  input  logic [PIX_W-1:0] cell0_i,
  input  logic [PIX_W-1:0] cell1_i,
  input  logic             push_ready_i,
  output logic             push_valid_o,
  output res_t             push_data_o,
  output chain_ctl_t       chain_o,
  output logic             flushing_o
);

  state_e           state_q, state_d;
  logic [COL_W-1:0] fcnt_q, fcnt_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [PIX_W-1:0] prev_q;
  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  logic [PIX_W-1:0] decay_q;
  logic             border_q;

  logic [WID_W-1:0] w_eff, w_m1;
  logic [HGT_W-1:0] h_eff, h_m1;
  logic             acc, last, res_ok, on_border;
  logic [PIX_W-1:0] cur;
  logic [9:0]       sum;
  logic [PIX_W-1:0] avg, dot;
  logic             cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  always_comb begin
    w_eff = width_q;
    if (width_q < WIDTH_MIN) w_eff = WIDTH_MIN;
    if (width_q > WIDTH_MAX) w_eff = WIDTH_MAX;
    h_eff = height_q;
    if (height_q < HEIGHT_MIN) h_eff = HEIGHT_MIN;
    if (height_q > HEIGHT_MAX) h_eff = HEIGHT_MAX;
  end

  assign w_m1 = w_eff - WID_W'(1);
  assign h_m1 = h_eff - HGT_W'(1);

  assign last      = ({1'b0, row_q} >= h_m1) && (col_q >= w_m1);
  assign on_border = (row_q == '0) || ({1'b0, row_q} >= h_m1) ||
                     (col_q == '0) || (col_q >= w_m1);
  assign cur       = (border_q && on_border) ? '0 : in_i.pixel_in;
  // Position reaches width+1 from row 2 on, or row 1 past column 0.
  assign res_ok    = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));

  assign sum = 10'(cell0_i) + 10'(cell1_i) + 10'(prev_q) + 10'(cur);
  assign avg = sum[9:2];
  assign dot = (avg <= decay_q) ? '0 : avg - decay_q;

  assign in_i.ready = (state_q == ST_RUN) && push_ready_i;
  assign acc        = in_i.valid && in_i.ready;
  assign flushing_o = (state_q == ST_FLUSH);

  always_comb begin
    state_d         = state_q;
    fcnt_d          = fcnt_q;
    col_d           = col_q;
    row_d           = row_q;
    push_valid_o    = 1'b0;
    push_data_o     = '{pixel_out: dot, last_of_frame: 1'b0};
    chain_o.shift   = 1'b0;
    chain_o.ins_pix = cur;
    chain_o.width   = w_eff;
    case (state_q)
      ST_RUN: begin
        if (acc) begin
          chain_o.shift = 1'b1;
          push_valid_o  = res_ok;
          if (last) begin
            col_d   = '0;
            row_d   = '0;
            fcnt_d  = COL_W'(w_eff) + COL_W'(1);
            state_d = ST_FLUSH;
          end else if (col_q >= w_m1) begin
            col_d = '0;
            row_d = row_q + ROW_W'(1);
          end else begin
            col_d = col_q + COL_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        // Tail pixels leave oldest first from the low end of the chain.
        if (push_ready_i) begin
          chain_o.shift = 1'b1;
          push_valid_o  = 1'b1;
          push_data_o   = '{pixel_out: cell0_i, last_of_frame: (fcnt_q == COL_W'(1))};
          fcnt_d        = fcnt_q - COL_W'(1);
          if (fcnt_q == COL_W'(1)) begin
            state_d = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
    if (cfg_wr && ((cfg_reg_e'(cfg_i.index) == REG_FRAME_WIDTH) ||
                   (cfg_reg_e'(cfg_i.index) == REG_FRAME_HEIGHT))) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RUN;
      fcnt_q   <= '0;
      col_q    <= '0;
      row_q    <= '0;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      decay_q  <= DECAY_RST;
      border_q <= BORDER_RST;
    end else begin
      state_q <= state_d;
      fcnt_q  <= fcnt_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (cfg_wr) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_FRAME_WIDTH:  width_q  <= cfg_i.data[WID_W-1:0];
          REG_FRAME_HEIGHT: height_q <= cfg_i.data[HGT_W-1:0];
          REG_DECAY_AMOUNT: decay_q  <= cfg_i.data[PIX_W-1:0];
          REG_CLEAR_BORDER: border_q <= cfg_i.data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      prev_q <= cur;
    end
  end

endmodule

// ===== rtl/core/box_blur_2x2_decay_top.sv =====
// Top level: 2x2 box blur with decay over a raster pixel stream.
// Throughput: one pixel per cycle unless the output buffer is full or a flush is running.
// Each input transfer yields at most one blurred result, queued in the output buffer.
// End of frame: the last pixel is followed by a flush of width+1 tail pixels, drained
// from the window chain, during which in_i is held not ready.
// Reset: control and registers reset at once (45, 35, 8, 1); window cells hold no reset value.
`timescale 1ns / 1ps
module box_blur_2x2_decay_top import bb2d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bb2d_pix_if.sink    in_i,
  bb2d_cfg_if.sink    cfg_i,
  bb2d_res_if.source  out_o
);

  logic [PIX_W-1:0] cell_pix [NCELL];
  chain_ctl_t       chain;
  logic             push_valid, push_ready, flushing;
  res_t             push_data;

  bb2d_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .cell0_i      (cell_pix[0]),
    .cell1_i      (cell_pix[1]),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .chain_o      (chain),
    .flushing_o   (flushing)
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic [PIX_W-1:0] next_pix;
    if (k == NCELL - 1) begin : g_end
      assign next_pix = chain.ins_pix;
    end else begin : g_mid
      assign next_pix = cell_pix[k+1];
    end
    bb2d_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (chain),
      .idx_i  (WID_W'(k)),
      .next_i (next_pix),
      .pix_o  (cell_pix[k])
    );
  end

  bb2d_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .out_o        (out_o)
  );

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("result pushed into a full output buffer");

  a_in_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (push_ready && !flushing))
    else $error("input taken without room for its result or during flush");

  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (flushing || !push_ready))
    else $error("input stalled with no flush and free output room");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the 2x2 box blur with decay: directed and random frames.
`timescale 1ns / 1ps
module testbench;
  import bb2d_pkg::*;

  logic clk_i;
  logic rst_ni;

  bb2d_pix_if pix_if ();
  bb2d_cfg_if cfg_if ();
  bb2d_res_if res_if ();

  box_blur_2x2_decay_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_if.sink),
    .cfg_i  (cfg_if.sink),
    .out_o  (res_if.source)
  );

  // Predictor copy of registers, window history and frame position
  logic [WID_W-1:0] reg_width;
  logic [HGT_W-1:0] reg_height;
  logic [PIX_W-1:0] reg_decay;
  logic             reg_border;
  logic [PIX_W-1:0] pixel_hist [NCELL];
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  res_t             blur_expect_q [$];

  int unsigned fail_count     = 0;
  int unsigned send_gap_pct   = 32;
  int unsigned recv_stall_pct = 53;
  int unsigned hold_cycles    = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL box_blur_2x2_decay_top");
    $finish;
  end

  function automatic int unsigned eff_w();
    if (reg_width < WIDTH_MIN) return WIDTH_MIN;
    if (reg_width > WIDTH_MAX) return WIDTH_MAX;
    return reg_width;
  endfunction

  function automatic int unsigned eff_h();
    if (reg_height < HEIGHT_MIN) return HEIGHT_MIN;
    if (reg_height > HEIGHT_MAX) return HEIGHT_MAX;
    return reg_height;
  endfunction

  function automatic void push_result(input logic [PIX_W-1:0] px, input logic last);
    res_t r;
    r.pixel_out     = px;
    r.last_of_frame = last;
    blur_expect_q.push_back(r);
  endfunction

  // Works out the results of one accepted pixel and advances the frame position.
  function automatic void blur_predict(input logic [PIX_W-1:0] px);
    int unsigned      w, h, col, row, n, sum, avg;
    logic [PIX_W-1:0] cur;
    bit               last;
    w    = eff_w();
    h    = eff_h();
    col  = col_cnt;
    row  = row_cnt;
    cur  = px;
    n    = row * w + col;
    last = (row >= h - 1) && (col >= w - 1);
    if (col >= w) col = w - 1;
    if (reg_border && (row == 0 || row >= h - 1 || col == 0 || col >= w - 1))
      cur = '0;
    if (n >= w + 1) begin
      sum = pixel_hist[w] + pixel_hist[w - 1] + pixel_hist[0] + cur;
      avg = (sum >> 2) & 'hFF;
      avg = (avg <= reg_decay) ? 0 : avg - reg_decay;
      push_result(PIX_W'(avg), 1'b0);
    end
    // tail pixels go out as stored, oldest first
    if (last) begin
      for (int k = w; k >= 1; k--) push_result(pixel_hist[k - 1], 1'b0);
      push_result(cur, 1'b1);
    end
    for (int k = NCELL - 1; k > 0; k--) pixel_hist[k] = pixel_hist[k - 1];
    pixel_hist[0] = cur;
    if (last) begin
      col_cnt = 0;
      row_cnt = 0;
    end else if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1) & 'h3F;
    end else begin
      col_cnt = (col + 1) & 'h3F;
    end
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid    <= 1'b1;
    pix_if.pixel_in <= px;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    blur_predict(px);
  endtask

  // Waits until every expected result is back or a spin limit is hit, then idles.
  task automatic drain();
    int unsigned spin;
    spin = 0;
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (blur_expect_q.size() != 0 && spin < 20000) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_FRAME_WIDTH: begin
        reg_width = data[WID_W-1:0];
        col_cnt   = 0;
        row_cnt   = 0;
      end
      REG_FRAME_HEIGHT: begin
        reg_height = data[HGT_W-1:0];
        col_cnt    = 0;
        row_cnt    = 0;
      end
      REG_DECAY_AMOUNT: reg_decay  = data[PIX_W-1:0];
      REG_CLEAR_BORDER: reg_border = data[0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Consumer side: checks each result transfer, then picks ready for the next cycle.
  initial begin : result_check
    res_t want;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (blur_expect_q.size() == 0) begin
          $error("unexpected result: pixel_out %0d last_of_frame %0b",
                 res_if.pixel_out, res_if.last_of_frame);
          fail_count++;
        end else begin
          want = blur_expect_q.pop_front();
          if (res_if.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %0d, actual %0d", want.pixel_out, res_if.pixel_out);
            fail_count++;
          end
          if (res_if.last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %0b, actual %0b",
                   want.last_of_frame, res_if.last_of_frame);
            fail_count++;
          end
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles  = hold_cycles - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Partial frame at reset geometry (warm-up only), then a width write restarts it.
  task automatic test_warmup_restart();
    for (int i = 0; i < 4; i++) send_pixel(PIX_W'(8'h11 * (i + 1)));
    drain();
    write_reg(REG_FRAME_WIDTH, 8'd3);
    write_reg(REG_FRAME_HEIGHT, 8'd2);
    write_reg(REG_DECAY_AMOUNT, 8'd0);
    write_reg(REG_CLEAR_BORDER, 8'd0);
    for (int i = 0; i < 6; i++) send_pixel(PIX_W'(8'h2A * (i + 1)));
    drain();
  endtask

  // Smallest frame with full-scale pixels, no decay and full decay.
  task automatic test_decay_extremes();
    write_reg(REG_FRAME_WIDTH, 8'd2);
    write_reg(REG_FRAME_HEIGHT, 8'd2);
    repeat (4) send_pixel('1);
    drain();
    write_reg(REG_DECAY_AMOUNT, 8'd255);
    repeat (4) send_pixel('1);
    drain();
  endtask

  // 3x3 with border clearing; only the center survives. Decay changes mid-frame.
  task automatic test_border_clear();
    logic [PIX_W-1:0] pat [9] = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'hC8,
                                   8'h01, 8'hFE, 8'h55, 8'hAA};
    write_reg(REG_FRAME_WIDTH, 8'd3);
    write_reg(REG_FRAME_HEIGHT, 8'd3);
    write_reg(REG_DECAY_AMOUNT, 8'd0);
    write_reg(REG_CLEAR_BORDER, 8'd1);
    for (int i = 0; i < 5; i++) send_pixel(pat[i]);
    drain();
    write_reg(REG_DECAY_AMOUNT, 8'd1);
    for (int i = 5; i < 9; i++) send_pixel(pat[i]);
    drain();
  endtask

  // Out-of-range and extra-bit register values; the tall frame is cut short.
  task automatic test_geometry_extremes();
    write_reg(REG_FRAME_WIDTH, 8'hC1);   // 1 after masking, clamps to 2
    write_reg(REG_FRAME_HEIGHT, 8'h80);  // 0 after masking, clamps to 2
    write_reg(REG_DECAY_AMOUNT, 8'd5);
    write_reg(REG_CLEAR_BORDER, 8'hFE);
    repeat (eff_w() * eff_h()) send_pixel(rand_pixel());
    drain();
    write_reg(REG_FRAME_WIDTH, 8'h41);   // 1 -> 2
    write_reg(REG_FRAME_HEIGHT, 8'h7F);  // 127 -> 64
    write_reg(REG_CLEAR_BORDER, 8'hFF);
    repeat (8) send_pixel(rand_pixel());
    drain();
    write_reg(REG_FRAME_WIDTH, 8'h40);
    write_reg(REG_FRAME_HEIGHT, 8'h01);
    repeat (4) send_pixel(rand_pixel());
    drain();
  endtask

  // Output held off for a long stretch while pixels keep coming.
  task automatic test_output_stall();
    write_reg(REG_FRAME_WIDTH, 8'd5);
    write_reg(REG_FRAME_HEIGHT, 8'd4);
    write_reg(REG_DECAY_AMOUNT, 8'd2);
    write_reg(REG_CLEAR_BORDER, 8'd0);
    hold_cycles = 150;
    repeat (20) send_pixel(rand_pixel());
    drain();
  endtask

  // Small whole frames of random content under random settings; some cut short.
  task automatic test_random_frames(input int unsigned n_items);
    int unsigned      sent, frame_len, count;
    logic [DATA_W-1:0] wdata, hdata;
    bit               first;
    sent  = 0;
    first = 1'b1;
    while (sent < n_items) begin
      if (first || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 4))
          0:       wdata = DATA_W'($urandom_range(0, 255)) & 8'hC7;
          default: wdata = DATA_W'($urandom_range(2, 6));
        endcase
        write_reg(REG_FRAME_WIDTH, wdata);
        hdata    = DATA_W'($urandom_range(0, 6));
        hdata[7] = 1'($urandom_range(0, 1));
        write_reg(REG_FRAME_HEIGHT, hdata);
      end
      if (first || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0:       write_reg(REG_DECAY_AMOUNT, 8'd0);
          1:       write_reg(REG_DECAY_AMOUNT, 8'd255);
          default: write_reg(REG_DECAY_AMOUNT, DATA_W'($urandom_range(0, 40)));
        endcase
      end
      if (first || $urandom_range(0, 1))
        write_reg(REG_CLEAR_BORDER, DATA_W'($urandom_range(0, 255)));
      frame_len = eff_w() * eff_h();
      count     = frame_len;
      // cut a frame short now and then; the next settings may restart it
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, frame_len - 1);
      repeat (count) begin
        send_pixel(rand_pixel());
        sent++;
      end
      drain();
      first = 1'b0;
    end
  endtask

  initial begin : stimulus
    pix_if.valid    <= 1'b0;
    pix_if.pixel_in <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_FRAME_WIDTH;
    cfg_if.data     <= '0;
    rst_ni          <= 1'b0;
    reg_width  = WIDTH_RST;
    reg_height = HEIGHT_RST;
    reg_decay  = DECAY_RST;
    reg_border = BORDER_RST;
    col_cnt    = 0;
    row_cnt    = 0;
    foreach (pixel_hist[k]) pixel_hist[k] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_warmup_restart();
    test_decay_extremes();
    test_border_clear();
    test_geometry_extremes();
    test_output_stall();
    test_random_frames(10);
    send_gap_pct   = 53;
    recv_stall_pct = 32;
    test_random_frames(10);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_frames(10);

    drain();
    repeat (8) @(posedge clk_i);
    if (blur_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", blur_expect_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS box_blur_2x2_decay_top");
    end else begin
      $display("FAIL box_blur_2x2_decay_top");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bb2d_pkg.sv
rtl/core/bb2d_if.sv
rtl/core/bb2d_cell.sv
rtl/core/bb2d_out_buf.sv
rtl/core/bb2d_ctrl.sv
rtl/core/box_blur_2x2_decay_top.sv
tb/testbench.sv
